// ===== rtl/core/osst_pkg.sv =====
// ----------------------------------------------------------------------------
// osst_pkg
// Shared constants, operation codes and types of the ordered sequence store.
// ----------------------------------------------------------------------------
`default_nettype none

package osst_pkg;

    // Sizes
    localparam int CAPACITY  = 16;
    localparam int DATA_W    = 32;
    localparam int FUNC_W    = 4;
    localparam int POS_W     = 5;
    localparam int STATUS_W  = 2;
    localparam int OUT_CNT_W = 5;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int CMP_W     = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // Operation codes
    localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 4'd0;
    localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 4'd1;
    localparam logic [FUNC_W-1:0] FN_POP_BACK   = 4'd2;
    localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 4'd3;
    localparam logic [FUNC_W-1:0] FN_READ       = 4'd4;
    localparam logic [FUNC_W-1:0] FN_WRITE      = 4'd5;
    localparam logic [FUNC_W-1:0] FN_INSERT     = 4'd6;
    localparam logic [FUNC_W-1:0] FN_ERASE      = 4'd7;
    localparam logic [FUNC_W-1:0] FN_CLEAR      = 4'd8;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

    // Cell source select
    typedef logic [1:0] cell_sel_t;
    localparam cell_sel_t SEL_HOLD  = 2'd0;
    localparam cell_sel_t SEL_LOAD  = 2'd1;
    localparam cell_sel_t SEL_LEFT  = 2'd2;
    localparam cell_sel_t SEL_RIGHT = 2'd3;

    // Per-cell control from the sequencer
    typedef struct packed {
        cell_sel_t sel;
        logic      read_hit;
        logic      first_hit;
        logic      last_hit;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/osst_if.sv =====
// ----------------------------------------------------------------------------
// osst_if
// Valid/ready channels: request items in, result items out.
// ----------------------------------------------------------------------------
`default_nettype none

interface osst_req_if;
    import osst_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [FUNC_W-1:0]          func;
    logic [POS_W-1:0]           position;
    logic signed [DATA_W-1:0]   value;

    modport source (output valid, output func, output position, output value, input ready);
    modport sink   (input valid, input func, input position, input value, output ready);
endinterface

interface osst_rsp_if;
    import osst_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic signed [DATA_W-1:0]   read_value;
    logic [OUT_CNT_W-1:0]       count;
    logic signed [DATA_W-1:0]   first_value;
    logic signed [DATA_W-1:0]   last_value;

    modport source (output valid, output status, output read_value, output count,
                    output first_value, output last_value, input ready);
    modport sink   (input valid, input status, input read_value, input count,
                    input first_value, input last_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/osst_cell.sv =====
// ----------------------------------------------------------------------------
// osst_cell
// One list slot: holds, loads, or takes the value of a neighbor each cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module osst_cell (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire osst_pkg::cell_ctrl_t            ctrl,
    input  wire logic [osst_pkg::DATA_W-1:0]     load_data,
    input  wire logic [osst_pkg::DATA_W-1:0]     left_data,
    input  wire logic [osst_pkg::DATA_W-1:0]     right_data,
    output logic      [osst_pkg::DATA_W-1:0]     data,
    output logic      [osst_pkg::DATA_W-1:0]     read_tap,
    output logic      [osst_pkg::DATA_W-1:0]     first_tap,
    output logic      [osst_pkg::DATA_W-1:0]     last_tap
);
    import osst_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    // source select
    always_comb
    begin
        case (ctrl.sel)
            SEL_LOAD:  data_next = load_data;
            SEL_LEFT:  data_next = left_data;
            SEL_RIGHT: data_next = right_data;
            default:   data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    // taps for the result: read sees the old value, front/back the new one
    assign data      = data_reg;
    assign read_tap  = ctrl.read_hit  ? data_reg  : '0;
    assign first_tap = ctrl.first_hit ? data_next : '0;
    assign last_tap  = ctrl.last_hit  ? data_next : '0;

endmodule

`default_nettype wire

// ===== rtl/core/osst_ctrl.sv =====
// ----------------------------------------------------------------------------
// osst_ctrl
// Sequencer: holds the entry count and drives the select of every cell.
// ----------------------------------------------------------------------------
`default_nettype none

module osst_ctrl (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             accept,
    input  wire logic [osst_pkg::FUNC_W-1:0]      func,
    input  wire logic [osst_pkg::POS_W-1:0]       position,
    output osst_pkg::cell_ctrl_t                  cell_ctrl [osst_pkg::CAPACITY],
    output logic      [osst_pkg::STATUS_W-1:0]    status,
    output logic      [osst_pkg::CNT_W-1:0]       count_next
);
    import osst_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CMP_W-1:0] n;
    logic [CMP_W-1:0] n_next;
    logic [CMP_W-1:0] p;
    logic [CMP_W-1:0] cap;
    logic             full;
    logic             empty;

    assign n     = CMP_W'(count_reg);
    assign p     = CMP_W'(position);
    assign cap   = CMP_W'(CAPACITY);
    assign full  = (n >= cap);
    assign empty = (n == '0);

    // status and new count
    always_comb
    begin
        status = ST_OK;
        n_next = n;
        unique case (func)
            FN_PUSH_BACK, FN_PUSH_FRONT:
            begin
                if (full) status = ST_FULL;
                else      n_next = n + 1'b1;
            end
            FN_POP_BACK, FN_POP_FRONT:
            begin
                if (empty) status = ST_BAD;
                else       n_next = n - 1'b1;
            end
            FN_INSERT:
            begin
                if (full)       status = ST_FULL;
                else if (p > n) status = ST_BAD;
                else            n_next = n + 1'b1;
            end
            FN_ERASE:
            begin
                if (p >= n) status = ST_BAD;
                else        n_next = n - 1'b1;
            end
            FN_CLEAR:
            begin
                n_next = '0;
            end
            default:
            begin
                n_next = n;
            end
        endcase
    end

    assign count_next = n_next[CNT_W-1:0];

    // per-cell selects and result taps
    always_comb
    begin
        logic [CMP_W-1:0] ii;
        ii = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            ii = CMP_W'(i);
            cell_ctrl[i].sel = SEL_HOLD;
            if (accept && status == ST_OK)
            begin
                case (func)
                    FN_PUSH_BACK:
                        if (ii == n) cell_ctrl[i].sel = SEL_LOAD;
                    FN_PUSH_FRONT:
                        if (ii == '0)    cell_ctrl[i].sel = SEL_LOAD;
                        else if (ii <= n) cell_ctrl[i].sel = SEL_LEFT;
                    FN_POP_FRONT:
                        if (ii + 1'b1 < n) cell_ctrl[i].sel = SEL_RIGHT;
                    FN_WRITE:
                        if (p < n)
                        begin
                            if (ii == p) cell_ctrl[i].sel = SEL_LOAD;
                        end
                        else if (!empty && ii == '0)
                        begin
                            cell_ctrl[i].sel = SEL_LOAD;
                        end
                    FN_INSERT:
                        if (ii == p)                cell_ctrl[i].sel = SEL_LOAD;
                        else if (ii > p && ii <= n) cell_ctrl[i].sel = SEL_LEFT;
                    FN_ERASE:
                        if (ii >= p && ii + 1'b1 < n) cell_ctrl[i].sel = SEL_RIGHT;
                    default:
                        cell_ctrl[i].sel = SEL_HOLD;
                endcase
            end
            // read past the end falls back to the front entry
            cell_ctrl[i].read_hit  = (func == FN_READ) &&
                                     ((p < n && ii == p) || (p >= n && !empty && ii == '0));
            cell_ctrl[i].first_hit = (n_next != '0) && (ii == '0);
            cell_ctrl[i].last_hit  = (n_next != '0) && (ii == n_next - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ordered_sequence_store_top.sv =====
// ----------------------------------------------------------------------------
// ordered_sequence_store_top
// Bounded ordered list of signed 32-bit values held in a row of shift cells.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one operation per transfer (func, position, value): push or
//   pop at either end, indexed read or write, insert before, erase, clear.
//   rsp returns one result per request: status, read value, count after the
//   operation, and the front and back entries (0 when empty).
//   Every operation finishes in the cycle its request transfers: all cells
//   shift, load or hold together, so one request is taken per cycle while
//   rsp is not stalled. The result appears in the output register in the
//   cycle after the request transfer, sustaining one item per cycle.
//   The per-cell select logic of the sequencer and the front/back taps set
//   the path from request to output register.
//   While a result waits, req stays ready if rsp is taken in the same cycle;
//   a stalled rsp holds its result and blocks further requests.
//   Reset empties the list and clears all cells; no result is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_sequence_store_top (
    input  wire logic clk,
    input  wire logic rst_n,
    osst_req_if.sink  req,
    osst_rsp_if.source rsp
);
    import osst_pkg::*;

    cell_ctrl_t              cell_ctrl [CAPACITY];
    logic [DATA_W-1:0]       cell_data [CAPACITY];
    logic [DATA_W-1:0]       read_tap  [CAPACITY];
    logic [DATA_W-1:0]       first_tap [CAPACITY];
    logic [DATA_W-1:0]       last_tap  [CAPACITY];
    logic [STATUS_W-1:0]     status;
    logic [CNT_W-1:0]        count_next;
    logic                    accept;

    logic [DATA_W-1:0]       read_sum;
    logic [DATA_W-1:0]       first_sum;
    logic [DATA_W-1:0]       last_sum;

    logic                    rsp_valid_reg;
    logic [STATUS_W-1:0]     status_reg;
    logic [DATA_W-1:0]       read_value_reg;
    logic [OUT_CNT_W-1:0]    count_reg;
    logic [DATA_W-1:0]       first_value_reg;
    logic [DATA_W-1:0]       last_value_reg;

    // handshake: take a request when the output slot is free or draining
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    osst_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .func       (req.func),
        .position   (req.position),
        .cell_ctrl  (cell_ctrl),
        .status     (status),
        .count_next (count_next)
    );

    // cell chain, front at index 0
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [DATA_W-1:0] left_data;
        logic [DATA_W-1:0] right_data;

        if (g == 0)
        begin : g_front
            assign left_data = '0;
        end
        else
        begin : g_mid_l
            assign left_data = cell_data[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_back
            assign right_data = '0;
        end
        else
        begin : g_mid_r
            assign right_data = cell_data[g+1];
        end

        osst_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (cell_ctrl[g]),
            .load_data  (req.value),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[g]),
            .read_tap   (read_tap[g]),
            .first_tap  (first_tap[g]),
            .last_tap   (last_tap[g])
        );
    end

    // collect the one-hot taps
    always_comb
    begin
        read_sum  = '0;
        first_sum = '0;
        last_sum  = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            read_sum  = read_sum  | read_tap[i];
            first_sum = first_sum | first_tap[i];
            last_sum  = last_sum  | last_tap[i];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg      <= status;
            read_value_reg  <= read_sum;
            count_reg       <= OUT_CNT_W'(count_next);
            first_value_reg <= first_sum;
            last_value_reg  <= last_sum;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.read_value  = read_value_reg;
    assign rsp.count       = count_reg;
    assign rsp.first_value = first_value_reg;
    assign rsp.last_value  = last_value_reg;

endmodule

`default_nettype wire
